// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked on every rising clock edge out of reset
`define MAC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// implication, consequent in the same cycle
`define MAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication, consequent in the next cycle
`define MAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/macage_pkg.sv =====
`timescale 1ns / 1ps
package macage_pkg;

  localparam logic [1:0] ACT_UPDATE   = 2'd0;
  localparam logic [1:0] ACT_BY_KEY   = 2'd1;
  localparam logic [1:0] ACT_BY_SHORT = 2'd2;
  localparam logic [1:0] ACT_TICK     = 2'd3;

  localparam logic [1:0] KIND_UPDATE  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  localparam logic [1:0] MEDIA_WIFI   = 2'd0;
  localparam logic [1:0] MEDIA_BLE    = 2'd1;
  localparam logic [1:0] MEDIA_LOWPAN = 2'd2;

  localparam logic [2:0] REG_LOCAL_NODE   = 3'd0;
  localparam logic [2:0] REG_LOCAL_SHORT  = 3'd1;
  localparam logic [2:0] REG_LOCAL_NET    = 3'd2;
  localparam logic [2:0] REG_WIFI_TMO     = 3'd3;
  localparam logic [2:0] REG_BLE_TMO      = 3'd4;
  localparam logic [2:0] REG_LOWPAN_TMO   = 3'd5;

  localparam logic [7:0] AGE_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] node_key;
    logic [15:0] short_id;
    logic [15:0] network_id;
    logic [15:0] via_short_id;
    logic [15:0] via_network_id;
    logic [1:0]  media;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] out_node_key;
    logic [15:0] out_short_id;
    logic [15:0] out_network_id;
    logic [15:0] out_via_short_id;
    logic [15:0] out_via_network_id;
    logic [1:0]  out_media;
    logic [5:0]  entry_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] local_node_id;
    logic [15:0] local_short_id;
    logic [15:0] local_network_id;
    logic [7:0]  wifi_timeout;
    logic [7:0]  ble_timeout;
    logic [7:0]  lowpan_timeout;
  } cfg_t;

  typedef enum logic [2:0] {
    CLS_UPDATE,
    CLS_LOCAL,
    CLS_BY_KEY,
    CLS_BY_SHORT,
    CLS_TICK
  } cls_t;

  typedef struct packed {
    cls_t     cls;
    in_item_t item;
  } req_t;

  typedef struct packed {
    logic [63:0] node_key;
    logic [15:0] short_id;
    logic [15:0] network_id;
    logic [15:0] via_short_id;
    logic [15:0] via_network_id;
    logic [1:0]  media;
    logic [7:0]  age;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CHECK,
    B_COMMIT,
    B_EMIT
  } back_state_t;

endpackage

// ===== design/macage_ram.sv =====
`timescale 1ns / 1ps
module macage_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/macage_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module macage_front import macage_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     q_valid,
  input  logic     q_ready,
  output req_t     q_req
);

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  req_t       slots [2];
  req_t       req_in;
  logic       push;
  logic       pop;

  always_comb begin
    req_in.item = in_data;
    unique case (in_data.action)
      ACT_UPDATE:   req_in.cls = CLS_UPDATE;
      ACT_BY_KEY:   req_in.cls = (in_data.node_key == cfg.local_node_id) ? CLS_LOCAL
                                                                         : CLS_BY_KEY;
      ACT_BY_SHORT: req_in.cls = CLS_BY_SHORT;
      default:      req_in.cls = CLS_TICK;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
  end

  `MAC_ASSERT(fifo_bound, count <= 2'd2)
  `MAC_ASSERT_IMP(fifo_ptrs, count == 2'd0 || count == 2'd2, wr_ptr == rd_ptr)

endmodule

// ===== design/macage_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module macage_back import macage_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  req_t      q_req,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  back_state_t         state;
  back_state_t         state_next;
  req_t                req;
  logic [IDX_W-1:0]    idx;
  logic                pass2;
  logic                found;
  logic                full;
  logic [IDX_W-1:0]    sel_idx;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  entry_t              hit_e;
  logic [5:0]          exp_cnt;
  logic [5:0]          cnt_final;
  logic [CAPACITY-1:0] valid_bits;
  logic [5:0]          valid_count;

  entry_t              rd_data;
  entry_t              wr_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;

  entry_t              e;
  logic                v;
  logic [7:0]          age_n;
  logic [7:0]          tmo;
  logic                expired;
  logic                search_hit;
  logic                last_slot;
  logic                out_free;
  logic                emit_exp;
  out_item_t           res_final;
  out_item_t           res_exp;

  macage_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  always_comb begin
    e         = rd_data;
    v         = valid_bits[idx];
    age_n     = (e.age == AGE_MAX) ? AGE_MAX : e.age + 8'd1;
    case (e.media)
      MEDIA_WIFI:   tmo = cfg.wifi_timeout;
      MEDIA_BLE:    tmo = cfg.ble_timeout;
      MEDIA_LOWPAN: tmo = cfg.lowpan_timeout;
      default:      tmo = 8'd0;
    endcase
    expired   = v && (age_n > tmo);
    last_slot = (idx == LAST_IDX);
    out_free  = !out_valid || out_ready;
    case (req.cls) inside
      CLS_UPDATE, CLS_BY_KEY: search_hit = v && (e.node_key == req.item.node_key);
      CLS_BY_SHORT: search_hit = v && (e.short_id == req.item.short_id)
                                   && (e.network_id == req.item.network_id);
      default:      search_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (q_req.cls == CLS_LOCAL) ? B_EMIT : B_READ;
        end
      end
      B_READ: state_next = B_CHECK;
      B_CHECK: begin
        case (req.cls)
          CLS_TICK: begin
            if (!pass2) begin
              state_next = B_READ;
            end else if (expired && !out_free) begin
              state_next = B_CHECK;
            end else begin
              state_next = last_slot ? B_EMIT : B_READ;
            end
          end
          CLS_UPDATE: state_next = (search_hit || last_slot) ? B_COMMIT : B_READ;
          default:    state_next = (search_hit || last_slot) ? B_EMIT : B_READ;
        endcase
      end
      B_COMMIT: state_next = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_ready  = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_data  = e;
    wr_data.age = age_n;
    emit_exp = 1'b0;
    unique case (state)
      B_IDLE: q_ready = 1'b1;
      B_CHECK: begin
        if (req.cls == CLS_TICK && pass2) begin
          wr_en    = v && !expired;
          emit_exp = expired && out_free;
        end
      end
      B_COMMIT: begin
        wr_en   = found || free_found;
        wr_addr = found ? sel_idx : free_idx;
        wr_data.node_key       = req.item.node_key;
        wr_data.short_id       = req.item.short_id;
        wr_data.network_id     = req.item.network_id;
        wr_data.via_short_id   = req.item.via_short_id;
        wr_data.via_network_id = req.item.via_network_id;
        wr_data.media          = req.item.media;
        wr_data.age            = 8'd0;
      end
      default: q_ready = 1'b0;
    endcase
  end

  always_comb begin
    res_exp                    = '0;
    res_exp.kind               = KIND_EXPIRED;
    res_exp.status             = STAT_OK;
    res_exp.out_node_key       = e.node_key;
    res_exp.out_short_id       = e.short_id;
    res_exp.out_network_id     = e.network_id;
    res_exp.out_via_short_id   = e.via_short_id;
    res_exp.out_via_network_id = e.via_network_id;
    res_exp.out_media          = e.media;
    res_exp.entry_count        = cnt_final;
    res_exp.last               = 1'b0;

    res_final             = '0;
    res_final.entry_count = valid_count;
    res_final.last        = 1'b1;
    case (req.cls) inside
      CLS_UPDATE: begin
        res_final.kind = KIND_UPDATE;
        if (full) begin
          res_final.status = STAT_FULL;
        end else begin
          res_final.out_node_key       = req.item.node_key;
          res_final.out_short_id       = req.item.short_id;
          res_final.out_network_id     = req.item.network_id;
          res_final.out_via_short_id   = req.item.via_short_id;
          res_final.out_via_network_id = req.item.via_network_id;
          res_final.out_media          = req.item.media;
        end
      end
      CLS_LOCAL: begin
        res_final.kind           = KIND_LOOKUP;
        res_final.out_node_key   = cfg.local_node_id;
        res_final.out_short_id   = cfg.local_short_id;
        res_final.out_network_id = cfg.local_network_id;
      end
      CLS_BY_KEY, CLS_BY_SHORT: begin
        res_final.kind = KIND_LOOKUP;
        if (found) begin
          res_final.out_node_key       = hit_e.node_key;
          res_final.out_short_id       = hit_e.short_id;
          res_final.out_network_id     = hit_e.network_id;
          res_final.out_via_short_id   = hit_e.via_short_id;
          res_final.out_via_network_id = hit_e.via_network_id;
        end else begin
          res_final.status = STAT_NOT_FOUND;
        end
      end
      default: res_final.kind = KIND_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      valid_bits  <= '0;
      valid_count <= 6'd0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit_exp) begin
        valid_bits[idx] <= 1'b0;
        valid_count     <= valid_count - 6'd1;
        out_valid       <= 1'b1;
      end
      if (state == B_COMMIT && !found && free_found) begin
        valid_bits[free_idx] <= 1'b1;
        valid_count          <= valid_count + 6'd1;
      end
      if (state == B_EMIT && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      req        <= q_req;
      idx        <= '0;
      pass2      <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      exp_cnt    <= 6'd0;
    end
    if (state == B_CHECK) begin
      if (search_hit) begin
        found   <= 1'b1;
        sel_idx <= idx;
        hit_e   <= e;
      end
      if (req.cls == CLS_UPDATE && !v && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      // first tick pass only counts, so every expired result carries the final count
      if (req.cls == CLS_TICK && !pass2) begin
        if (expired) begin
          exp_cnt <= exp_cnt + 6'd1;
        end
        if (last_slot) begin
          pass2     <= 1'b1;
          cnt_final <= valid_count - exp_cnt - {5'd0, expired};
        end
      end
      if (state_next == B_READ) begin
        idx <= last_slot ? '0 : idx + IDX_W'(1);
      end
    end
    if (state == B_COMMIT) begin
      full <= !found && !free_found;
    end
    if (emit_exp) begin
      out_data <= res_exp;
    end else if (state == B_EMIT && out_free) begin
      out_data <= res_final;
    end
  end

  `MAC_ASSERT(count_tracks_bits, valid_count == 6'($countones(valid_bits)))
  `MAC_ASSERT_IMP(drop_bounded, state == B_CHECK && pass2 && req.cls == CLS_TICK,
                  valid_count >= cnt_final)
  `MAC_ASSERT_NEXT(idle_takes_req, state == B_IDLE && q_valid,
                   state == B_READ || state == B_EMIT)

endmodule

// ===== design/mesh_address_cache_aging_top.sv =====
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------
// input     | in_valid / in_ready        | in_data  (in_item_t)
// output    | out_valid / out_ready      | out_data (out_item_t)
// config    | psel penable pwrite pready | paddr pwdata prdata
//
// a lookup or update scans the table one slot at a time (read, then check) and stops at a hit or the last slot
// a tick makes two scans (count, then age and drop); an expired result can stall the second scan on output
// a lookup of the local node id is answered without a scan; the slot store is one single-port-read RAM
// a two-deep request queue lets input be taken while the sequencer works or output stalls
// synchronous reset clears the slot valid bits and the count at once, no clearing pass
module mesh_address_cache_aging_top import macage_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       cfg_wr;
  logic [2:0] reg_sel;
  logic       q_valid;
  logic       q_ready;
  req_t       q_req;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LOCAL_NODE:  cfg.local_node_id    <= pwdata;
        REG_LOCAL_SHORT: cfg.local_short_id   <= pwdata[15:0];
        REG_LOCAL_NET:   cfg.local_network_id <= pwdata[15:0];
        REG_WIFI_TMO:    cfg.wifi_timeout     <= pwdata[7:0];
        REG_BLE_TMO:     cfg.ble_timeout      <= pwdata[7:0];
        REG_LOWPAN_TMO:  cfg.lowpan_timeout   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOCAL_NODE:  prdata = cfg.local_node_id;
      REG_LOCAL_SHORT: prdata = {48'd0, cfg.local_short_id};
      REG_LOCAL_NET:   prdata = {48'd0, cfg.local_network_id};
      REG_WIFI_TMO:    prdata = {56'd0, cfg.wifi_timeout};
      REG_BLE_TMO:     prdata = {56'd0, cfg.ble_timeout};
      REG_LOWPAN_TMO:  prdata = {56'd0, cfg.lowpan_timeout};
      default:         prdata = 64'd0;
    endcase
  end

  macage_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req)
  );

  macage_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req),
    .cfg      (cfg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
